>>> design/las_pkg.sv
// ----------------------------------------------------------------------------
// las_pkg
// Shared types, constants and a helper function for the Lorenz attractor
// stepper: register indexes, sequencer step codes and the DAC level mapping.
// ----------------------------------------------------------------------------
package las_pkg;

   // configuration register indexes
   localparam logic [1:0] CSR_SIGMA = 2'd0;
   localparam logic [1:0] CSR_RHO   = 2'd1;
   localparam logic [1:0] CSR_BETA  = 2'd2;

   localparam int CoefWidth = 31;
   localparam int DtWidth   = 24;

   // coefficient reset values
   localparam logic [CoefWidth-1:0] SIGMA_RESET = 31'd167772160;
   localparam logic [CoefWidth-1:0] RHO_RESET   = 31'd469762048;
   localparam logic [CoefWidth-1:0] BETA_RESET  = 31'd44739242;

   // dac offset for x and y
   localparam logic signed [18:0] LEVEL_OFFSET = 19'sd32769;

   // controller states
   typedef enum logic [1:0] {
      FSM_IDLE,
      FSM_CALC,
      FSM_COMMIT
   } fsm_type;

   // one multiply per step; the tail step only drains the last product
   typedef enum logic [3:0] {
      STEP_SIGMA,
      STEP_RHO,
      STEP_SZ,
      STEP_SY,
      STEP_BETA,
      STEP_XLO,
      STEP_XHI,
      STEP_YLO,
      STEP_YHI,
      STEP_ZLO,
      STEP_ZHI,
      STEP_TAIL
   } step_type;

   // controller to datapath commands
   typedef struct packed {
      logic     load;
      logic     issue;
      step_type step;
      logic     commit;
   } cmd_type;

   // clamp((3*w >>> 16) + offset, 0, 65535)
   function automatic logic [15:0] level_of(input logic [31:0] w, input logic offs);
      logic signed [33:0] p;
      logic signed [18:0] q;
      logic [15:0]        r;
      p = $signed({{2{w[31]}}, w}) + $signed({w[31], w, 1'b0});
      q = $signed({p[33], p[33:16]}) + (offs ? LEVEL_OFFSET : 19'sd0);
      if (q[18]) begin
         r = 16'd0;
      end else if (q[17:16] != 2'b00) begin
         r = 16'hFFFF;
      end else begin
         r = q[15:0];
      end
      return r;
   endfunction

endpackage

>>> design/las_if.sv
// ----------------------------------------------------------------------------
// las_if
// Valid/ready channel interfaces for the tick requests and the state results.
// ----------------------------------------------------------------------------
interface las_req_if;
   logic        valid;
   logic        ready;
   logic [23:0] step_size;
   logic        restart;

   modport source (output valid, output step_size, output restart, input ready);
   modport sink   (input valid, input step_size, input restart, output ready);
endinterface

interface las_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] out_x;
   logic signed [31:0] out_y;
   logic signed [31:0] out_z;
   logic [15:0]        level_x;
   logic [15:0]        level_y;
   logic [15:0]        level_z;

   modport source (output valid, output out_x, output out_y, output out_z,
                   output level_x, output level_y, output level_z, input ready);
   modport sink   (input valid, input out_x, input out_y, input out_z,
                   input level_x, input level_y, input level_z, output ready);
endinterface

>>> design/las_ctrl.sv
// ----------------------------------------------------------------------------
// las_ctrl
// Sequencer for one Euler step: accepts a tick, walks the datapath through
// its multiply steps and hands the result to the output register.
// ----------------------------------------------------------------------------
module las_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output las_pkg::cmd_type cmd
);
   import las_pkg::*;

   fsm_type  state_ff, state_in;
   step_type step_ff, step_in;
   logic     rsp_valid_ff, rsp_valid_in;

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FSM_IDLE;
         step_ff      <= STEP_SIGMA;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         FSM_IDLE: begin
            if (cmd.load) state_in = FSM_CALC;
         end
         FSM_CALC: begin
            if (step_ff == STEP_TAIL) state_in = FSM_COMMIT;
         end
         FSM_COMMIT: begin
            if (cmd.commit) state_in = FSM_IDLE;
         end
         default: state_in = FSM_IDLE;
      endcase
   end

   // outputs and step counter
   always_comb begin
      req_ready  = (state_ff == FSM_IDLE) && !reset;
      cmd.load   = req_valid && req_ready;
      cmd.issue  = (state_ff == FSM_CALC);
      cmd.step   = step_ff;
      cmd.commit = (state_ff == FSM_COMMIT) && (!rsp_valid_ff || rsp_ready);
      step_in    = (state_ff == FSM_CALC) ? step_type'(step_ff + 4'd1) : STEP_SIGMA;
      rsp_valid  = rsp_valid_ff;
   end

   // output register occupancy
   always_comb begin
      priority if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

endmodule

>>> design/las_dpath.sv
// ----------------------------------------------------------------------------
// las_dpath
// Datapath: coefficient registers, state registers, one shared 33x33 signed
// multiplier with a product register, accumulation and the output register.
// ----------------------------------------------------------------------------
module las_dpath #(
   parameter int FRAC_BITS = 24
) (
   input  logic               clock,
   input  logic               reset,
   input  las_pkg::cmd_type   cmd,
   input  logic               csr_we,
   input  logic [1:0]         csr_index,
   input  logic [30:0]        csr_wdata,
   input  logic [23:0]        step_size,
   input  logic               restart,
   output logic signed [31:0] out_x,
   output logic signed [31:0] out_y,
   output logic signed [31:0] out_z,
   output logic [15:0]        level_x,
   output logic [15:0]        level_y,
   output logic [15:0]        level_z
);
   import las_pkg::*;

   // bits of a derivative term that reach the low 32 bits of the new state
   localparam int TW = FRAC_BITS + 32;
   localparam logic [31:0] INIT_X = 32'((64'd1 << FRAC_BITS) / 64'd10);

   logic [CoefWidth-1:0] sigma_ff, rho_ff, beta_ff;
   logic [31:0]          pos_x_ff, pos_y_ff, pos_z_ff;
   logic [31:0]          nx_ff, ny_ff, nz_ff;
   logic [DtWidth-1:0]   dt_ff;
   logic [63:0]          prod_ff;
   logic [63:0]          acc_ff;
   logic [TW-1:0]        tx_ff, ty_ff, tz_ff;
   logic                 issued_ff;
   step_type             prv_ff;
   logic signed [31:0]   out_x_ff, out_y_ff, out_z_ff;
   logic [15:0]          level_x_ff, level_y_ff, level_z_ff;

   logic signed [32:0] mul_a, mul_b;
   logic signed [65:0] mul_p;
   logic [31:0]        dxy;
   logic [63:0]        prod_asr, diff_asr, sy64;
   logic [TW-1:0]      sum;
   logic [31:0]        inc;
   logic [31:0]        sel_pos;

   // coefficient registers
   always_ff @(posedge clock) begin
      if (reset) begin
         sigma_ff <= SIGMA_RESET;
         rho_ff   <= RHO_RESET;
         beta_ff  <= BETA_RESET;
      end else if (csr_we) begin
         if (csr_index == CSR_SIGMA) sigma_ff <= csr_wdata;
         if (csr_index == CSR_RHO)   rho_ff   <= csr_wdata;
         if (csr_index == CSR_BETA)  beta_ff  <= csr_wdata;
      end
   end

   // multiplier operand selection
   assign dxy = pos_y_ff - pos_x_ff;
   always_comb begin
      unique case (cmd.step)
         STEP_SIGMA: begin mul_a = $signed(33'(sigma_ff));      mul_b = $signed({dxy[31], dxy}); end
         STEP_RHO:   begin mul_a = $signed({pos_x_ff[31], pos_x_ff}); mul_b = $signed(33'(rho_ff)); end
         STEP_SZ:    begin mul_a = $signed({pos_x_ff[31], pos_x_ff});
                           mul_b = $signed({pos_z_ff[31], pos_z_ff}); end
         STEP_SY:    begin mul_a = $signed({pos_x_ff[31], pos_x_ff});
                           mul_b = $signed({pos_y_ff[31], pos_y_ff}); end
         STEP_BETA:  begin mul_a = $signed(33'(beta_ff));
                           mul_b = $signed({pos_z_ff[31], pos_z_ff}); end
         STEP_XLO:   begin mul_a = $signed(33'(dt_ff)); mul_b = $signed(33'(tx_ff[31:0])); end
         STEP_XHI:   begin mul_a = $signed(33'(dt_ff)); mul_b = $signed(33'(tx_ff[TW-1:32])); end
         STEP_YLO:   begin mul_a = $signed(33'(dt_ff)); mul_b = $signed(33'(ty_ff[31:0])); end
         STEP_YHI:   begin mul_a = $signed(33'(dt_ff)); mul_b = $signed(33'(ty_ff[TW-1:32])); end
         STEP_ZLO:   begin mul_a = $signed(33'(dt_ff)); mul_b = $signed(33'(tz_ff[31:0])); end
         STEP_ZHI:   begin mul_a = $signed(33'(dt_ff)); mul_b = $signed(33'(tz_ff[TW-1:32])); end
         default:    begin mul_a = 33'sd0; mul_b = 33'sd0; end
      endcase
   end
   assign mul_p = mul_a * mul_b;

   // shifted forms of the last product
   assign prod_asr = 64'($signed(prod_ff) >>> FRAC_BITS);
   assign diff_asr = 64'($signed(acc_ff - prod_ff) >>> FRAC_BITS);
   assign sy64     = {{32{pos_y_ff[31]}}, pos_y_ff};

   // dt times a term: low partial product plus high partial product shifted up
   assign sum = acc_ff[TW-1:0] + {prod_ff[TW-33:0], 32'd0};
   assign inc = sum[TW-1:FRAC_BITS];

   always_comb begin
      unique case (prv_ff)
         STEP_YHI: sel_pos = pos_y_ff;
         STEP_ZHI: sel_pos = pos_z_ff;
         default:  sel_pos = pos_x_ff;
      endcase
   end

   // sequencing registers
   always_ff @(posedge clock) begin
      if (reset) begin
         issued_ff <= 1'b0;
      end else begin
         issued_ff <= cmd.issue;
      end
   end

   // multiply, then consume the registered product in the next cycle
   always_ff @(posedge clock) begin
      prv_ff <= cmd.step;
      if (cmd.issue) prod_ff <= mul_p[63:0];
      if (cmd.load) dt_ff <= step_size;
      if (issued_ff) begin
         unique case (prv_ff)
            STEP_SIGMA: tx_ff  <= prod_asr[TW-1:0];
            STEP_RHO:   acc_ff <= prod_ff;
            STEP_SZ:    ty_ff  <= TW'(diff_asr - sy64);
            STEP_SY:    acc_ff <= prod_asr;
            STEP_BETA:  tz_ff  <= TW'(acc_ff - prod_asr);
            STEP_XLO, STEP_YLO, STEP_ZLO: acc_ff <= prod_ff;
            STEP_XHI:   nx_ff  <= sel_pos + inc;
            STEP_YHI:   ny_ff  <= sel_pos + inc;
            STEP_ZHI:   nz_ff  <= sel_pos + inc;
            default: ;
         endcase
      end
   end

   // state registers: restart reload and commit of the new state
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_x_ff <= INIT_X;
         pos_y_ff <= 32'd0;
         pos_z_ff <= 32'd0;
      end else if (cmd.load && restart) begin
         pos_x_ff <= INIT_X;
         pos_y_ff <= 32'd0;
         pos_z_ff <= 32'd0;
      end else if (cmd.commit) begin
         pos_x_ff <= nx_ff;
         pos_y_ff <= ny_ff;
         pos_z_ff <= nz_ff;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         out_x_ff   <= $signed(nx_ff);
         out_y_ff   <= $signed(ny_ff);
         out_z_ff   <= $signed(nz_ff);
         level_x_ff <= level_of(nx_ff, 1'b1);
         level_y_ff <= level_of(ny_ff, 1'b1);
         level_z_ff <= level_of(nz_ff, 1'b0);
      end
   end

   assign out_x   = out_x_ff;
   assign out_y   = out_y_ff;
   assign out_z   = out_z_ff;
   assign level_x = level_x_ff;
   assign level_y = level_y_ff;
   assign level_z = level_z_ff;

endmodule

>>> design/lorenz_attractor_stepper.sv
// ----------------------------------------------------------------------------
// lorenz_attractor_stepper
// Each tick advances the Lorenz system by one forward Euler step in signed
// fixed point (FRAC_BITS fraction bits) and returns the new x, y, z state with
// three clamped 16-bit DAC levels. A tick with restart set first reloads
// x = 0.1, y = 0, z = 0. A tick is accepted, runs eleven products through a
// single shared 33x33 signed multiplier plus a drain step, then commits to
// the output register once it is empty or its result is being taken. The
// next tick is accepted as soon as the result is in the output register,
// even while it waits to be taken. The user must write coefficients through
// the csr port only while no tick is in flight; the block does not enforce it.
// ----------------------------------------------------------------------------
module lorenz_attractor_stepper #(
   parameter int FRAC_BITS = 24
) (
   input  logic        clock,
   input  logic        reset,
   las_req_if.sink     req_if,
   las_rsp_if.source   rsp_if,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [30:0] csr_wdata
);
   import las_pkg::*;

   cmd_type cmd;

   // controller
   las_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .cmd       (cmd)
   );

   // datapath
   las_dpath #(
      .FRAC_BITS (FRAC_BITS)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .step_size (req_if.step_size),
      .restart   (req_if.restart),
      .out_x     (rsp_if.out_x),
      .out_y     (rsp_if.out_y),
      .out_z     (rsp_if.out_z),
      .level_x   (rsp_if.level_x),
      .level_y   (rsp_if.level_y),
      .level_z   (rsp_if.level_z)
   );

   // no second transaction while a step is in progress
   assert property (@(posedge clock) disable iff (reset)
      req_if.valid && req_if.ready |=> !req_if.ready)
      else $error("request accepted during a step");

   // an accepted tick starts the multiply sequence at its first step
   assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> cmd.issue && (cmd.step == STEP_SIGMA))
      else $error("sequence did not start after accept");

   // a commit always presents a result on the next cycle
   assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_if.valid)
      else $error("commit without result");

   // the sequencer never commits while multiplies are still issuing
   assert property (@(posedge clock) disable iff (reset)
      !(cmd.commit && cmd.issue))
      else $error("commit overlaps multiply sequence");

endmodule

>>> tb/tb_lorenz_attractor_stepper.sv
// ----------------------------------------------------------------------------
// tb_lorenz_attractor_stepper
// Self-checking bench for the Lorenz attractor stepper. A queue of ticks feeds
// a bursty driver; every accepted tick is run through a fixed-point Euler
// predictor and the expected state and DAC levels are queued. A monitor with
// its own stall pattern compares each result field by field. Coefficients
// are changed between phases while the block is idle, including the extremes.
// ----------------------------------------------------------------------------
module tb_lorenz_attractor_stepper;
   import las_pkg::*;

   localparam int FRAC = 24;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int SETTLE_CYCLES = 24;
   localparam logic [1:0] CSR_UNMAPPED = 2'd3;
   localparam logic signed [31:0] START_X = 32'sd1677721;
   localparam logic [23:0] DT_MAX = 24'hFFFFFF;
   localparam logic [30:0] COEF_MAX = 31'h7FFFFFFF;

   typedef struct {
      logic [23:0] dt;
      logic        restart;
   } tick_type;

   typedef struct {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
      logic [15:0]        lx;
      logic [15:0]        ly;
      logic [15:0]        lz;
   } lorenz_state_type;

   logic        clock;
   logic        reset;
   logic        csr_we;
   logic [1:0]  csr_index;
   logic [30:0] csr_wdata;

   las_req_if req_ch ();
   las_rsp_if rsp_ch ();

   lorenz_attractor_stepper dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_ch),
      .rsp_if    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // predictor copy of coefficients and trajectory
   logic [30:0]        sigma_q;
   logic [30:0]        rho_q;
   logic [30:0]        beta_q;
   logic signed [31:0] traj_x;
   logic signed [31:0] traj_y;
   logic signed [31:0] traj_z;

   tick_type         pending_ticks[$];
   lorenz_state_type expected_states[$];
   tick_type         next_tick;
   lorenz_state_type got_state;
   lorenz_state_type want_state;

   int error_count;
   int gap_left;
   int burst_left;
   int ready_run;
   int idle_cycles;
   bit no_idle;

   // 50 MHz style clock, period 20
   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // clamp((3*w >>> 16) + offset) into the dac range
   function automatic logic [15:0] dac_level(input logic signed [31:0] w,
                                             input longint offs);
      longint tripled;
      longint q;
      tripled = longint'(w) * 3;
      q = (tripled >>> 16) + offs;
      if (q < 0) begin
         q = 0;
      end else if (q > 65535) begin
         q = 65535;
      end
      return q[15:0];
   endfunction

   // one forward euler step, all products wrap in 64 bits
   task automatic euler_advance(input logic [23:0] dt, input logic restart);
      logic signed [63:0] sx;
      logic signed [63:0] sy;
      logic signed [63:0] sz;
      logic signed [63:0] dt_w;
      logic signed [63:0] diff;
      logic signed [63:0] t;
      logic signed [63:0] u;
      logic signed [31:0] d32;
      lorenz_state_type   r;
      if (restart) begin
         traj_x = START_X;
         traj_y = '0;
         traj_z = '0;
      end
      sx = {{32{traj_x[31]}}, traj_x};
      sy = {{32{traj_y[31]}}, traj_y};
      sz = {{32{traj_z[31]}}, traj_z};
      dt_w = {40'd0, dt};

      // x: sigma * (y - x), difference wraps in 32 bits
      d32 = traj_y - traj_x;
      diff = {{32{d32[31]}}, d32};
      t = {33'd0, sigma_q} * diff;
      t = t >>> FRAC;
      t = dt_w * t;
      t = t >>> FRAC;
      t = sx + t;
      r.x = t[31:0];

      // y: x * (rho - z) - y
      diff = {33'd0, rho_q} - sz;
      t = sx * diff;
      t = t >>> FRAC;
      t = t - sy;
      t = dt_w * t;
      t = t >>> FRAC;
      t = sy + t;
      r.y = t[31:0];

      // z: x * y - beta * z
      t = sx * sy;
      t = t >>> FRAC;
      u = {33'd0, beta_q} * sz;
      u = u >>> FRAC;
      t = t - u;
      t = dt_w * t;
      t = t >>> FRAC;
      t = sz + t;
      r.z = t[31:0];

      traj_x = r.x;
      traj_y = r.y;
      traj_z = r.z;
      r.lx = dac_level(r.x, 64'sd32769);
      r.ly = dac_level(r.y, 64'sd32769);
      r.lz = dac_level(r.z, 64'sd0);
      expected_states.push_back(r);
   endtask

   function automatic void check_field(input string name, input longint want,
                                       input longint got);
      if (want != got) begin
         $display("%0t mismatch %s expected %0d actual %0d", $time, name, want, got);
         error_count++;
      end
   endfunction

   // driver: bursts of ticks with random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         gap_left <= 0;
         burst_left <= 1;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            euler_advance(req_ch.step_size, req_ch.restart);
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (gap_left > 0 && !no_idle) begin
               gap_left <= gap_left - 1;
               req_ch.valid <= 1'b0;
            end else if (pending_ticks.size() > 0) begin
               next_tick = pending_ticks.pop_front();
               req_ch.valid <= 1'b1;
               req_ch.step_size <= next_tick.dt;
               req_ch.restart <= next_tick.restart;
               if (burst_left <= 1) begin
                  burst_left <= $urandom_range(1, 16);
                  gap_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30)
                                                          : $urandom_range(0, 4);
               end else begin
                  burst_left <= burst_left - 1;
               end
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // monitor: compare each result transaction, stall on random runs
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         ready_run <= 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            got_state.x = rsp_ch.out_x;
            got_state.y = rsp_ch.out_y;
            got_state.z = rsp_ch.out_z;
            got_state.lx = rsp_ch.level_x;
            got_state.ly = rsp_ch.level_y;
            got_state.lz = rsp_ch.level_z;
            if (expected_states.size() == 0) begin
               $display("%0t unexpected result x %0d y %0d z %0d", $time,
                        got_state.x, got_state.y, got_state.z);
               error_count++;
            end else begin
               want_state = expected_states.pop_front();
               check_field("out_x", longint'(want_state.x), longint'(got_state.x));
               check_field("out_y", longint'(want_state.y), longint'(got_state.y));
               check_field("out_z", longint'(want_state.z), longint'(got_state.z));
               check_field("level_x", longint'(want_state.lx), longint'(got_state.lx));
               check_field("level_y", longint'(want_state.ly), longint'(got_state.ly));
               check_field("level_z", longint'(want_state.lz), longint'(got_state.lz));
            end
         end
         if (no_idle) begin
            rsp_ch.ready <= 1'b1;
         end else if (ready_run == 0) begin
            rsp_ch.ready <= !rsp_ch.ready;
            if (rsp_ch.ready) begin
               ready_run <= ($urandom_range(0, 15) == 0) ? $urandom_range(20, 40)
                                                         : $urandom_range(1, 8);
            end else begin
               ready_run <= $urandom_range(1, 20);
            end
         end else begin
            ready_run <= ready_run - 1;
         end
      end
   end

   // watchdog on cycles without any transaction
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic write_coef(input logic [1:0] idx, input logic [30:0] value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_SIGMA: sigma_q = value;
         CSR_RHO:   rho_q = value;
         CSR_BETA:  beta_q = value;
         default:   ;
      endcase
   endtask

   task automatic add_tick(input logic [23:0] dt, input logic restart);
      tick_type t;
      t.dt = dt;
      t.restart = restart;
      pending_ticks.push_back(t);
   endtask

   // restart then a run of small steps, with some noise mixed in
   task automatic add_random_ticks(input int count);
      int made;
      int run;
      made = 0;
      while (made < count) begin
         add_tick(24'($urandom_range(1, 40000)), 1'b1);
         made++;
         run = $urandom_range(8, 40);
         for (int i = 0; i < run && made < count; i++) begin
            case ($urandom_range(0, 19))
               0:       add_tick(24'($urandom_range(0, DT_MAX)), 1'($urandom_range(0, 1)));
               1:       add_tick(24'($urandom_range(0, 400000)), 1'b0);
               default: add_tick(24'($urandom_range(1, 40000)), 1'b0);
            endcase
            made++;
         end
      end
   endtask

   // wait until every tick is taken and every result is checked
   task automatic wait_quiet();
      do begin
         @(posedge clock);
      end while (pending_ticks.size() != 0 || req_ch.valid || expected_states.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = CSR_SIGMA;
      csr_wdata = '0;
      req_ch.valid = 1'b0;
      req_ch.step_size = '0;
      req_ch.restart = 1'b0;
      rsp_ch.ready = 1'b0;
      error_count = 0;
      idle_cycles = 0;
      no_idle = 1'b0;
      sigma_q = SIGMA_RESET;
      rho_q = RHO_RESET;
      beta_q = BETA_RESET;
      traj_x = START_X;
      traj_y = '0;
      traj_z = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // reset coefficients: step size extremes, restart on and off
      add_tick(24'd0, 1'b0);
      add_tick(24'd1, 1'b0);
      add_tick(24'd16777, 1'b0);
      add_tick(24'd16777, 1'b0);
      add_tick(DT_MAX, 1'b0);
      add_tick(DT_MAX, 1'b0);
      add_tick(24'd16777, 1'b1);
      add_tick(24'd16777, 1'b0);
      add_tick(24'h800000, 1'b0);
      add_tick(DT_MAX, 1'b0);
      add_tick(DT_MAX, 1'b0);
      add_tick(24'd0, 1'b1);
      add_tick(24'h555555, 1'b0);
      add_tick(24'hAAAAAA, 1'b1);
      add_tick(DT_MAX, 1'b1);
      add_tick(24'd1, 1'b1);
      add_random_ticks(110);
      wait_quiet();

      // all coefficients at maximum
      write_coef(CSR_SIGMA, COEF_MAX);
      write_coef(CSR_RHO, COEF_MAX);
      write_coef(CSR_BETA, COEF_MAX);
      add_tick(24'd1, 1'b1);
      add_tick(24'd16777, 1'b0);
      add_tick(DT_MAX, 1'b0);
      add_tick(DT_MAX, 1'b0);
      add_random_ticks(60);
      wait_quiet();

      // all coefficients at zero
      write_coef(CSR_SIGMA, '0);
      write_coef(CSR_RHO, '0);
      write_coef(CSR_BETA, '0);
      add_tick(DT_MAX, 1'b1);
      add_tick(DT_MAX, 1'b0);
      add_random_ticks(50);
      wait_quiet();

      // random coefficients, unmapped index must be ignored
      write_coef(CSR_SIGMA, 31'($urandom_range(0, COEF_MAX)));
      write_coef(CSR_RHO, 31'($urandom_range(0, COEF_MAX)));
      write_coef(CSR_BETA, 31'($urandom_range(0, COEF_MAX)));
      write_coef(CSR_UNMAPPED, 31'($urandom_range(0, COEF_MAX)));
      add_random_ticks(60);
      wait_quiet();

      // back to classic sigma and rho with a random beta, first without any idling
      write_coef(CSR_SIGMA, SIGMA_RESET);
      write_coef(CSR_RHO, RHO_RESET);
      write_coef(CSR_BETA, 31'($urandom_range(20000000, 60000000)));
      no_idle = 1'b1;
      add_random_ticks(60);
      wait_quiet();
      no_idle = 1'b0;
      add_random_ticks(100);
      wait_quiet();

      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
